### rtl/tcs_pkg.sv
package tcs_pkg;

	localparam logic [7:0]  PROTO_RESET = 8'd6;
	localparam logic [15:0] SKIP_FIRST  = 16'd16;
	localparam logic [15:0] SKIP_SECOND = 16'd17;
	localparam logic [15:0] SUM_ONES    = 16'hFFFF;

	typedef enum logic {
		CMD_ADDR = 1'b0,
		CMD_BYTE = 1'b1
	} cmd_t;

	typedef struct packed {
		cmd_t        command;
		logic [15:0] value;
		logic        last;
	} item_t;

	// input register contents handed to the accumulator
	typedef struct packed {
		logic  valid;
		item_t item;
	} stage_t;

	// ones-complement add with end-around carry
	function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[15:0] + {15'd0, s[16]};
	endfunction

endpackage

### rtl/tcs_in_if.sv
interface tcs_in_if;
	import tcs_pkg::*;

	logic        valid;
	logic        ready;
	cmd_t        command;
	logic [15:0] value;
	logic        last;

	modport source (output valid, output command, output value, output last, input ready);
	modport sink   (input valid, input command, input value, input last, output ready);

endinterface

### rtl/tcs_out_if.sv
interface tcs_out_if;

	logic        valid;
	logic        ready;
	logic [15:0] checksum;

	modport source (output valid, output checksum, input ready);
	modport sink   (input valid, input checksum, output ready);

endinterface

### rtl/tcs_input_stage.sv
module tcs_input_stage (
	input  logic            clk,
	input  logic            arst_n,
	tcs_in_if.sink          item,
	input  logic            take,
	output tcs_pkg::stage_t stage
);
	import tcs_pkg::*;

	logic  valid_s1;
	item_t item_s1;
	logic  accept;

	assign item.ready = !valid_s1 || take;
	assign accept     = item.valid && item.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.command <= item.command;
			item_s1.value   <= item.value;
			item_s1.last    <= item.last;
		end
	end

	assign stage.valid = valid_s1;
	assign stage.item  = item_s1;

endmodule

### rtl/tcs_accum.sv
module tcs_accum (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [7:0]      cfg_data,
	input  tcs_pkg::stage_t stage,
	output logic            take,
	tcs_out_if.source       result
);
	import tcs_pkg::*;

	logic [7:0]  proto_q;
	logic [15:0] sum_q;
	logic [15:0] count_q;
	logic [7:0]  hb_q;
	logic        hp_q;
	logic        out_valid_q;
	logic [15:0] checksum_q;

	logic [15:0] sum_n;
	logic [15:0] count_n;
	logic [7:0]  hb_n;
	logic        hp_n;
	logic        skip;
	logic [17:0] total;
	logic [16:0] fold1;
	logic [15:0] fold2;
	logic [15:0] csum;

	// advance a held word unless it is a last word and a finished checksum is still waiting
	assign take = stage.valid && (!stage.item.last || !out_valid_q || result.ready);

	assign skip = (count_q == SKIP_FIRST) || (count_q == SKIP_SECOND);

	always_comb begin
		sum_n   = sum_q;
		count_n = count_q;
		hb_n    = hb_q;
		hp_n    = hp_q;
		case (stage.item.command)
			CMD_ADDR: begin
				sum_n = oc_add(sum_q, stage.item.value);
			end
			CMD_BYTE: begin
				count_n = count_q + 16'd1;
				if (!skip) begin
					if (!count_q[0]) begin
						hb_n = stage.item.value[7:0];
						hp_n = 1'b1;
					end else begin
						sum_n = oc_add(sum_q, {hb_q, stage.item.value[7:0]});
						hp_n  = 1'b0;
					end
				end
			end
			default: begin
				sum_n = sum_q;
			end
		endcase
	end

	// sum the closing terms wide, then fold the carries back twice
	always_comb begin
		total = {2'b00, sum_n} + {2'b00, count_n} + {10'd0, proto_q}
			+ (hp_n ? {2'b00, hb_n, 8'h00} : 18'd0);
		fold1 = {1'b0, total[15:0]} + {15'd0, total[17:16]};
		fold2 = fold1[15:0] + {15'd0, fold1[16]};
		csum  = ~fold2;
		if (csum == 16'd0) begin
			csum = SUM_ONES;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			proto_q     <= PROTO_RESET;
			sum_q       <= 16'd0;
			count_q     <= 16'd0;
			hb_q        <= 8'd0;
			hp_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				proto_q <= cfg_data;
			end
			if (take && stage.item.last) begin
				sum_q       <= 16'd0;
				count_q     <= 16'd0;
				hb_q        <= 8'd0;
				hp_q        <= 1'b0;
				out_valid_q <= 1'b1;
			end else begin
				if (take) begin
					sum_q   <= sum_n;
					count_q <= count_n;
					hb_q    <= hb_n;
					hp_q    <= hp_n;
				end
				if (result.ready) begin
					out_valid_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && stage.item.last) begin
			checksum_q <= csum;
		end
	end

	assign result.valid    = out_valid_q;
	assign result.checksum = checksum_q;

endmodule

### rtl/tcp_segment_checksum_unit.sv
// TCP checksum with pseudo-header, one word per cycle unless a waiting result stalls it.
// A last word passes the input register, then the result register, before its
// checksum shows; a finished checksum still waiting can stall it in between.
// One word per cycle while no waiting checksum stalls the input; set by the single ones-complement add loop.
// Reset: arst_n clears the running sum, byte count and valid flags at once;
// protocol number returns to 6.
module tcp_segment_checksum_unit (
	input  logic       clk,
	input  logic       arst_n,
	tcs_in_if.sink     item,
	tcs_out_if.source  result,
	input  logic       cfg_we,
	input  logic [7:0] cfg_data
);
	import tcs_pkg::*;

	stage_t stage;
	logic   take;

	// Hold the accepted word; refill in the same cycle the accumulator takes it.
	tcs_input_stage u_input (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.take   (take),
		.stage  (stage)
	);

	// Pair bytes, skip the checksum field, add into the running sum, and on the
	// last word add length and protocol, complement and register the result.
	// A non-last word always advances, so the result register only stalls the
	// input when a second last word reaches it before the first is taken.
	tcs_accum u_accum (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.stage    (stage),
		.take     (take),
		.result   (result)
	);

endmodule

### rtl/tcs_checker.sv
module tcs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        in_last,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] out_checksum
);

	// a stalled checksum holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_checksum))
		else $error("checksum word changed while stalled");

	// zero is always replaced by all ones
	a_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_checksum != 16'd0)
		else $error("checksum word is zero");

	// with the result register empty the input never stalls
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty result register");

	// a new result follows a last word taken through the input and result registers
	a_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready && in_last, 2))
		else $error("result without a last word");

endmodule

bind tcp_segment_checksum_unit tcs_checker u_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (item.valid),
	.in_ready     (item.ready),
	.in_last      (item.last),
	.out_valid    (result.valid),
	.out_ready    (result.ready),
	.out_checksum (result.checksum)
);

### tb/sv/tcp_segment_checksum_unit_test.sv
module tcp_segment_checksum_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	import tcs_pkg::*;

	// Run limits and pacing
	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int SETTLE_CYCLES = 4;      // a last word passes the input and result registers before its checksum shows
	localparam int RANDOM_WORDS  = 700;
	localparam int RANDOM_SUMS   = 48;     // keep going until this many checksums are predicted
	localparam int WRAP_BYTES    = 65536 + 21;
	localparam int HOLD_CYCLES   = 400;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [7:0] cfg_data;

	tcs_in_if  item_bus ();
	tcs_out_if result_bus ();

	tcp_segment_checksum_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item_bus),
		.result   (result_bus),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	// Mirror of the checksum engine: protocol register plus the per-packet state
	logic [7:0]  proto_num;
	logic [15:0] sum_acc;
	logic [15:0] seg_len;
	logic [7:0]  held_byte;
	bit          held_valid;

	// Checksums predicted but not yet seen on the result channel, oldest first
	logic [15:0] pending_sums[$];

	int err_count     = 0;
	int word_count    = 0;
	int sum_count     = 0;
	int cycle_count   = 0;
	bit idle_on       = 1'b1;
	int hold_request  = 0;

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Count cycles; give up at the limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("tcp_segment_checksum_unit test failed");
		$finish;
	end

	// Ones-complement add: fold the carry out of bit 15 back into bit 0
	function automatic logic [15:0] fold_add(input logic [15:0] x, input logic [15:0] y);
		logic [31:0] t;
		t = {16'd0, x} + {16'd0, y};
		t = {16'd0, t[15:0]} + {16'd0, t[31:16]};
		return t[15:0];
	endfunction

	function automatic void clear_packet_state();
		sum_acc    = '0;
		seg_len    = '0;
		held_byte  = '0;
		held_valid = 1'b0;
	endfunction

	// Advance the mirror by one accepted word; queue a checksum when the word closes a packet
	function automatic void predict_word(input cmd_t cmd, input logic [15:0] val,
			input logic lst);
		logic [15:0] s;
		logic [15:0] c;
		if (cmd == CMD_ADDR) begin
			// address words go straight into the sum, wherever they fall in the packet
			sum_acc = fold_add(sum_acc, val);
		end else begin
			// the two checksum field bytes never enter the sum, also after the count wraps
			if (seg_len != SKIP_FIRST && seg_len != SKIP_SECOND) begin
				if (!seg_len[0]) begin
					held_byte  = val[7:0];
					held_valid = 1'b1;
				end else begin
					sum_acc    = fold_add(sum_acc, {held_byte, val[7:0]});
					held_valid = 1'b0;
				end
			end
			seg_len = seg_len + 16'd1;
		end
		if (lst) begin
			s = sum_acc;
			// pad an odd trailing byte with zero
			if (held_valid)
				s = fold_add(s, {held_byte, 8'h00});
			s = fold_add(s, seg_len);
			s = fold_add(s, {8'h00, proto_num});
			c = ~s;
			// an all-zero complement goes out as all ones
			if (c == 16'h0000)
				c = SUM_ONES;
			pending_sums.push_back(c);
			sum_count++;
			clear_packet_state();
		end
	endfunction

	// Mostly short gaps, some medium, a few long; none while idling is off
	function automatic int random_gap();
		int r;
		if (!idle_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Offer one word and hold it until the block takes it.
	// Handshakes are sampled at the falling edge, where nothing moves.
	task automatic send_word(input cmd_t cmd, input logic [15:0] val, input logic lst);
		int gap;
		bit took;
		gap = random_gap();
		if (gap > 0) begin
			item_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_bus.valid   <= 1'b1;
		item_bus.command <= cmd;
		item_bus.value   <= val;
		item_bus.last    <= lst;
		do begin
			@(negedge clk);
			took = item_bus.ready;
			@(posedge clk);
		end while (!took);
		predict_word(cmd, val, lst);
		word_count++;
	endtask

	// Well-formed packet: address words, then segment bytes, last on the final word
	task automatic send_packet(input int n_addr, input int n_bytes);
		for (int i = 0; i < n_addr; i++)
			send_word(CMD_ADDR, 16'($urandom_range(0, 16'hFFFF)),
				n_bytes == 0 && i == n_addr - 1);
		for (int i = 0; i < n_bytes; i++)
			send_word(CMD_BYTE, 16'($urandom_range(0, 16'hFFFF)), i == n_bytes - 1);
	endtask

	// Drop valid, wait for every predicted checksum, then let the pipeline empty
	task automatic settle_results();
		item_bus.valid <= 1'b0;
		while (pending_sums.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Only called with the block idle, right after settle_results or reset
	task automatic write_protocol(input logic [7:0] v);
		cfg_data <= v;
		cfg_we   <= 1'b1;
		@(posedge clk);
		cfg_we    <= 1'b0;
		proto_num  = v;
	endtask

	// Receiver: random stalls, plus a long hold-off on request
	initial begin
		int hold_left;
		int stall_left;
		hold_left        = 0;
		stall_left       = 0;
		result_bus.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request > 0) begin
				hold_left    = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				result_bus.ready <= 1'b0;
				hold_left--;
			end else if (stall_left > 0) begin
				result_bus.ready <= 1'b0;
				stall_left--;
			end else begin
				result_bus.ready <= 1'b1;
				if (idle_on && $urandom_range(0, 2) == 0)
					stall_left = random_gap();
			end
		end
	end

	// Compare every accepted checksum with the oldest prediction
	always @(negedge clk) begin
		logic [15:0] want;
		if (arst_n && result_bus.valid && result_bus.ready) begin
			if (pending_sums.size() == 0) begin
				$error("checksum: none expected, actual %h", result_bus.checksum);
				err_count++;
			end else begin
				want = pending_sums.pop_front();
				if (result_bus.checksum !== want) begin
					$error("checksum mismatch: expected %h, actual %h", want,
						result_bus.checksum);
					err_count++;
				end
			end
		end
	end

	// Packets with no segment data, and single-byte segments with junk in the upper bits
	task automatic test_empty_packets();
		send_word(CMD_ADDR, 16'hFFFF, 1'b1);
		send_word(CMD_BYTE, 16'hFF00, 1'b1);
		send_word(CMD_BYTE, 16'h00FF, 1'b1);
	endtask

	// Sum lands on all ones with the reset protocol, so the complement is zero
	task automatic test_zero_checksum();
		send_word(CMD_ADDR, 16'hFFF9, 1'b1);
	endtask

	// IPv4-style packet with an odd-length segment, a stray address word in the
	// middle, and a filled-in checksum field that must be skipped
	task automatic test_short_segment();
		logic [15:0] val;
		send_word(CMD_ADDR, 16'h0000, 1'b0);
		send_word(CMD_ADDR, 16'hFFFF, 1'b0);
		send_word(CMD_ADDR, 16'hA5A5, 1'b0);
		send_word(CMD_ADDR, 16'h5A5A, 1'b0);
		for (int i = 0; i < 19; i++) begin
			if (i == 5)
				send_word(CMD_ADDR, 16'h8001, 1'b0);
			if (i == 16 || i == 17)
				val = 16'hFFFF;
			else
				val = {8'(i * 29), 8'(255 - 13 * i)};
			send_word(CMD_BYTE, val, i == 18);
		end
	endtask

	// Protocol register at both extremes, then back to its reset value
	task automatic test_protocol_register();
		settle_results();
		write_protocol(8'h00);
		send_word(CMD_ADDR, 16'h0000, 1'b1);
		settle_results();
		write_protocol(8'hFF);
		send_word(CMD_BYTE, 16'h1234, 1'b1);
		send_packet(4, 20);
		settle_results();
		write_protocol(PROTO_RESET);
	endtask

	// One segment longer than 64 KiB: the length wraps and the checksum field
	// positions come round again
	task automatic test_length_wrap();
		idle_on = 1'b0;
		send_packet(4, WRAP_BYTES);
		settle_results();
		idle_on = 1'b1;
	endtask

	// Hold off the receiver while short packets keep coming, so the block fills
	// and stalls its input; then pause the sender until everything has drained
	task automatic test_backpressure();
		idle_on      = 1'b0;
		hold_request = HOLD_CYCLES;
		repeat (40)
			send_packet($urandom_range(0, 1), $urandom_range(1, 3));
		settle_results();
		idle_on = 1'b1;
	endtask

	// Mostly well-formed IPv4/IPv6 packets with random content, some noise, and
	// protocol changes between drained phases
	task automatic test_random_packets();
		int start_words;
		int start_sums;
		int r;
		int n_bytes;
		start_words = word_count;
		start_sums  = sum_count;
		while (word_count - start_words < RANDOM_WORDS || sum_count - start_sums < RANDOM_SUMS)
		begin
			if ($urandom_range(0, 11) == 0)
				idle_on = !idle_on;
			r = $urandom_range(0, 9);
			if (r < 7) begin
				r = $urandom_range(0, 19);
				if (r < 10)
					n_bytes = $urandom_range(0, 20);
				else if (r < 17)
					n_bytes = $urandom_range(18, 40);
				else
					n_bytes = $urandom_range(41, 160);
				send_packet($urandom_range(0, 1) ? 4 : 16, n_bytes);
			end else if (r < 9) begin
				// noise: any mix of words, packets closed at random
				repeat ($urandom_range(1, 10))
					send_word(cmd_t'($urandom_range(0, 1)), 16'($urandom_range(0, 16'hFFFF)),
						$urandom_range(0, 3) == 0);
			end else begin
				settle_results();
				case ($urandom_range(0, 3))
					0: write_protocol(8'h00);
					1: write_protocol(8'hFF);
					default: write_protocol(8'($urandom_range(0, 255)));
				endcase
			end
		end
		idle_on = 1'b1;
	endtask

	initial begin
		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_data         = '0;
		item_bus.valid   = 1'b0;
		item_bus.command = CMD_ADDR;
		item_bus.value   = '0;
		item_bus.last    = 1'b0;
		proto_num        = PROTO_RESET;
		clear_packet_state();

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_packets();
		test_zero_checksum();
		test_short_segment();
		test_protocol_register();
		test_length_wrap();
		test_backpressure();
		test_random_packets();

		settle_results();
		if (err_count == 0)
			$display("tcp_segment_checksum_unit test passed");
		else
			$display("tcp_segment_checksum_unit test failed");
		$finish;
	end

endmodule
